>>> rtl/hre_pkg.sv
// ----------------------------------------------------------------------------
// hre_pkg
// shared types, constants and helpers of the hex record encoder
// ----------------------------------------------------------------------------
package hre_pkg;

    localparam int unsigned TAPE_LINE_BYTES_DEF = 24;
    localparam int unsigned IHEX_LINE_BYTES_DEF = 32;
    localparam int unsigned QUEUE_DEPTH         = 4;

    localparam logic [1:0]  FMT_RAW  = 2'd0;
    localparam logic [1:0]  FMT_TAPE = 2'd1;
    localparam logic [1:0]  FMT_IHEX = 2'd2;
    localparam logic [1:0]  FMT_NONE = 2'd3;

    localparam logic [1:0]  REG_FORMAT = 2'd0;
    localparam logic [1:0]  REG_LENGTH = 2'd1;
    localparam logic [1:0]  REG_BASE   = 2'd2;

    localparam logic [1:0]  RST_FORMAT       = FMT_IHEX;
    localparam logic [16:0] RST_IMAGE_LENGTH = 17'd1;
    localparam logic [15:0] RST_BASE_ADDRESS = 16'd0;

    localparam logic [7:0]  CH_SEMI  = 8'h3B;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_ONE   = 8'h31;
    localparam logic [7:0]  CH_F     = 8'h46;
    localparam logic [7:0]  CH_NL    = 8'h0A;

    localparam logic [3:0]  TRL_LAST = 4'd11;

    typedef enum logic [4:0] {
        S_RAW,
        S_MARK,
        S_LEN_HI,
        S_LEN_LO,
        S_ADR_3,
        S_ADR_2,
        S_ADR_1,
        S_ADR_0,
        S_TYPE_HI,
        S_TYPE_LO,
        S_DAT_HI,
        S_DAT_LO,
        S_SUM_3,
        S_SUM_2,
        S_SUM_1,
        S_SUM_0,
        S_EOL,
        S_TRL
    } t_step;

    typedef struct packed {
        logic        raw;
        logic        tape;
        logic        head;
        logic        tail;
        logic        file_last;
        logic [7:0]  data;
        logic [7:0]  line_len;
        logic [15:0] line_addr;
        logic [15:0] chk;
        logic [15:0] lines;
        logic [15:0] lines_chk;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else begin
            c = 8'h37 + {4'd0, d};
        end
        return c;
    endfunction

endpackage

>>> rtl/hre_front.sv
// ----------------------------------------------------------------------------
// hre_front
// takes image bytes, tracks line state and builds one job per item
// ----------------------------------------------------------------------------
module hre_front #(
    parameter int unsigned TAPE_LINE_BYTES = hre_pkg::TAPE_LINE_BYTES_DEF,
    parameter int unsigned IHEX_LINE_BYTES = hre_pkg::IHEX_LINE_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_restart,
    input  logic [1:0]         i_format,
    input  logic [16:0]        i_image_length,
    input  logic [15:0]        i_base_address,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    output logic               o_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output hre_pkg::t_job      o_job
);

    logic [16:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_line_pos, n_line_pos;
    logic [7:0]  r_line_len, n_line_len;
    logic [15:0] r_line_addr, n_line_addr;
    logic [15:0] r_run_sum, n_run_sum;
    logic [15:0] r_lines, n_lines;

    logic        accept;
    logic        active;
    logic        raw;
    logic        tape;
    logic        first;
    logic        last;
    logic        tail;
    logic [16:0] bl_dec;
    logic [7:0]  per_line;
    logic [7:0]  len;
    logic [15:0] base_sum;
    logic [15:0] sum_new;
    logic [7:0]  pos_new;
    logic [15:0] lines_new;
    logic [7:0]  cc;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        active    = (r_bytes_left != 17'd0) && (i_format != hre_pkg::FMT_NONE);
        raw       = (i_format == hre_pkg::FMT_RAW);
        tape      = (i_format == hre_pkg::FMT_TAPE);
        bl_dec    = r_bytes_left - 17'd1;
        last      = (bl_dec == 17'd0);
        first     = (r_line_pos == 8'd0);
        per_line  = tape ? 8'(TAPE_LINE_BYTES) : 8'(IHEX_LINE_BYTES);
        if (first) begin
            len = (r_bytes_left > {9'd0, per_line}) ? per_line : r_bytes_left[7:0];
            base_sum = {8'd0, len} + {8'd0, r_line_addr[15:8]} + {8'd0, r_line_addr[7:0]};
        end else begin
            len      = r_line_len;
            base_sum = r_run_sum;
        end
        sum_new   = base_sum + {8'd0, i_data_byte};
        pos_new   = r_line_pos + 8'd1;
        tail      = (pos_new >= len) || last;
        lines_new = r_lines + 16'd1;
        cc        = ~sum_new[7:0] + 8'd1;

        o_job.raw       = raw;
        o_job.tape      = tape;
        o_job.head      = first;
        o_job.tail      = tail;
        o_job.file_last = last;
        o_job.data      = i_data_byte;
        o_job.line_len  = len;
        o_job.line_addr = r_line_addr;
        o_job.chk       = tape ? sum_new : {8'd0, cc};
        o_job.lines     = lines_new;
        o_job.lines_chk = {8'd0, lines_new[15:8]} + {8'd0, lines_new[7:0]};

        o_push = accept && active;

        n_bytes_left = r_bytes_left;
        n_line_pos   = r_line_pos;
        n_line_len   = r_line_len;
        n_line_addr  = r_line_addr;
        n_run_sum    = r_run_sum;
        n_lines      = r_lines;
        if (i_restart) begin
            n_bytes_left = i_image_length;
            n_line_pos   = 8'd0;
            n_line_len   = 8'd0;
            n_line_addr  = i_base_address;
            n_run_sum    = 16'd0;
            n_lines      = 16'd0;
        end else if (o_push) begin
            n_bytes_left = bl_dec;
            if (!raw) begin
                n_run_sum  = sum_new;
                n_line_len = len;
                if (tail) begin
                    n_line_addr = r_line_addr + {8'd0, pos_new};
                    n_lines     = lines_new;
                    n_line_pos  = 8'd0;
                end else begin
                    n_line_pos = pos_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= hre_pkg::RST_IMAGE_LENGTH;
            r_line_pos   <= 8'd0;
            r_line_len   <= 8'd0;
            r_line_addr  <= hre_pkg::RST_BASE_ADDRESS;
            r_run_sum    <= 16'd0;
            r_lines      <= 16'd0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_line_pos   <= n_line_pos;
            r_line_len   <= n_line_len;
            r_line_addr  <= n_line_addr;
            r_run_sum    <= n_run_sum;
            r_lines      <= n_lines;
        end
    end

endmodule

>>> rtl/hre_queue.sv
// ----------------------------------------------------------------------------
// hre_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module hre_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hre_pkg::t_job      i_job,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output hre_pkg::t_job      o_job
);

    localparam int unsigned AW = $clog2(hre_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(hre_pkg::QUEUE_DEPTH + 1);

    hre_pkg::t_job r_mem [hre_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(hre_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(hre_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(hre_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("job popped from empty queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue fill level lost a push");

endmodule

>>> rtl/hre_back.sv
// ----------------------------------------------------------------------------
// hre_back
// walks each job one character per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
module hre_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  hre_pkg::t_job      i_job,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_char,
    output logic               o_run_last,
    output logic               o_file_done
);

    logic               r_busy;
    hre_pkg::t_job      r_job;
    hre_pkg::t_step     r_step, n_step, first_step;
    logic [3:0]         r_trl_idx, n_trl_idx;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_run_last;
    logic               r_file_done;

    logic               slot_free;
    logic               emit;
    logic               done;
    logic               load;
    logic               last_char;
    logic [7:0]         ch;
    logic [7:0]         trl_ch;

    always_comb begin
        if (i_job.raw) begin
            first_step = hre_pkg::S_RAW;
        end else if (i_job.head) begin
            first_step = hre_pkg::S_MARK;
        end else begin
            first_step = hre_pkg::S_DAT_HI;
        end
    end

    always_comb begin
        if (r_job.tape) begin
            unique case (r_trl_idx)
                4'd0:                      trl_ch = hre_pkg::CH_SEMI;
                4'd1, 4'd2:                trl_ch = hre_pkg::CH_ZERO;
                4'd3:                      trl_ch = hre_pkg::hex_char(r_job.lines[15:12]);
                4'd4:                      trl_ch = hre_pkg::hex_char(r_job.lines[11:8]);
                4'd5:                      trl_ch = hre_pkg::hex_char(r_job.lines[7:4]);
                4'd6:                      trl_ch = hre_pkg::hex_char(r_job.lines[3:0]);
                4'd7:                      trl_ch = hre_pkg::hex_char(r_job.lines_chk[15:12]);
                4'd8:                      trl_ch = hre_pkg::hex_char(r_job.lines_chk[11:8]);
                4'd9:                      trl_ch = hre_pkg::hex_char(r_job.lines_chk[7:4]);
                4'd10:                     trl_ch = hre_pkg::hex_char(r_job.lines_chk[3:0]);
                default:                   trl_ch = hre_pkg::CH_NL;
            endcase
        end else begin
            unique case (r_trl_idx)
                4'd0:                      trl_ch = hre_pkg::CH_COLON;
                4'd1, 4'd2, 4'd3, 4'd4,
                4'd5, 4'd6, 4'd7:          trl_ch = hre_pkg::CH_ZERO;
                4'd8:                      trl_ch = hre_pkg::CH_ONE;
                4'd9, 4'd10:               trl_ch = hre_pkg::CH_F;
                default:                   trl_ch = hre_pkg::CH_NL;
            endcase
        end
    end

    always_comb begin
        n_step    = r_step;
        n_trl_idx = r_trl_idx;
        last_char = 1'b0;
        ch        = hre_pkg::CH_NL;
        unique case (r_step)
            hre_pkg::S_RAW: begin
                ch        = r_job.data;
                last_char = 1'b1;
            end
            hre_pkg::S_MARK: begin
                ch     = r_job.tape ? hre_pkg::CH_SEMI : hre_pkg::CH_COLON;
                n_step = hre_pkg::S_LEN_HI;
            end
            hre_pkg::S_LEN_HI: begin
                ch     = hre_pkg::hex_char(r_job.line_len[7:4]);
                n_step = hre_pkg::S_LEN_LO;
            end
            hre_pkg::S_LEN_LO: begin
                ch     = hre_pkg::hex_char(r_job.line_len[3:0]);
                n_step = hre_pkg::S_ADR_3;
            end
            hre_pkg::S_ADR_3: begin
                ch     = hre_pkg::hex_char(r_job.line_addr[15:12]);
                n_step = hre_pkg::S_ADR_2;
            end
            hre_pkg::S_ADR_2: begin
                ch     = hre_pkg::hex_char(r_job.line_addr[11:8]);
                n_step = hre_pkg::S_ADR_1;
            end
            hre_pkg::S_ADR_1: begin
                ch     = hre_pkg::hex_char(r_job.line_addr[7:4]);
                n_step = hre_pkg::S_ADR_0;
            end
            hre_pkg::S_ADR_0: begin
                ch     = hre_pkg::hex_char(r_job.line_addr[3:0]);
                n_step = r_job.tape ? hre_pkg::S_DAT_HI : hre_pkg::S_TYPE_HI;
            end
            hre_pkg::S_TYPE_HI: begin
                ch     = hre_pkg::CH_ZERO;
                n_step = hre_pkg::S_TYPE_LO;
            end
            hre_pkg::S_TYPE_LO: begin
                ch     = hre_pkg::CH_ZERO;
                n_step = hre_pkg::S_DAT_HI;
            end
            hre_pkg::S_DAT_HI: begin
                ch     = hre_pkg::hex_char(r_job.data[7:4]);
                n_step = hre_pkg::S_DAT_LO;
            end
            hre_pkg::S_DAT_LO: begin
                ch = hre_pkg::hex_char(r_job.data[3:0]);
                if (!r_job.tail) begin
                    last_char = 1'b1;
                end else if (r_job.tape) begin
                    n_step = hre_pkg::S_SUM_3;
                end else begin
                    n_step = hre_pkg::S_SUM_1;
                end
            end
            hre_pkg::S_SUM_3: begin
                ch     = hre_pkg::hex_char(r_job.chk[15:12]);
                n_step = hre_pkg::S_SUM_2;
            end
            hre_pkg::S_SUM_2: begin
                ch     = hre_pkg::hex_char(r_job.chk[11:8]);
                n_step = hre_pkg::S_SUM_1;
            end
            hre_pkg::S_SUM_1: begin
                ch     = hre_pkg::hex_char(r_job.chk[7:4]);
                n_step = hre_pkg::S_SUM_0;
            end
            hre_pkg::S_SUM_0: begin
                ch     = hre_pkg::hex_char(r_job.chk[3:0]);
                n_step = hre_pkg::S_EOL;
            end
            hre_pkg::S_EOL: begin
                ch = hre_pkg::CH_NL;
                if (r_job.file_last) begin
                    n_step    = hre_pkg::S_TRL;
                    n_trl_idx = 4'd0;
                end else begin
                    last_char = 1'b1;
                end
            end
            hre_pkg::S_TRL: begin
                ch = trl_ch;
                if (r_trl_idx == hre_pkg::TRL_LAST) begin
                    last_char = 1'b1;
                end else begin
                    n_trl_idx = r_trl_idx + 4'd1;
                end
            end
            default: begin
                ch        = hre_pkg::CH_NL;
                last_char = 1'b1;
            end
        endcase
    end

    assign slot_free = !r_out_valid || !i_out_stall;
    assign emit      = r_busy && slot_free;
    assign done      = emit && last_char;
    assign load      = (!r_busy || done) && !i_q_empty;
    assign o_pop     = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_char  <= ch;
            r_run_last  <= last_char;
            r_file_done <= last_char && r_job.file_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= hre_pkg::S_RAW;
            r_trl_idx   <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy    <= 1'b1;
                r_step    <= first_step;
                r_trl_idx <= 4'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_step    <= n_step;
                r_trl_idx <= n_trl_idx;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (slot_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_run_last  = r_run_last;
    assign o_file_done = r_file_done;

    a_done_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_file_done) |-> r_run_last)
        else $error("file end flagged on a character that does not close its item");

    a_trl_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == hre_pkg::S_TRL) |-> r_trl_idx <= hre_pkg::TRL_LAST)
        else $error("trailer index ran past the record");

    a_ihex_short_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_job.tape) |-> r_step != hre_pkg::S_SUM_3 && r_step != hre_pkg::S_SUM_2)
        else $error("intel record took the four digit checksum path");

endmodule

>>> rtl/hex_record_encoder_core.sv
// ----------------------------------------------------------------------------
// hex_record_encoder_core
// turns image bytes into a raw, paper-tape or intel hex object file
//
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_stall   i_data_byte
//   out       output      o_out_valid / i_out_stall o_out_char, o_run_last,
//                                                   o_file_done
//   config    input       psel / penable / pwrite   paddr, pwdata, prdata
//
// one output character per cycle from the back sequencer while not stalled;
// an item yields 1 character raw, 2 mid-line and up to 26 at image end
// the front takes an item a cycle until the four-deep job queue fills
// synchronous active-low reset; registers return to intel hex, length 1
// a format, length or base write restarts the run; output stall holds the back
// ----------------------------------------------------------------------------
module hex_record_encoder_core #(
    parameter int unsigned TAPE_LINE_BYTES = hre_pkg::TAPE_LINE_BYTES_DEF,
    parameter int unsigned IHEX_LINE_BYTES = hre_pkg::IHEX_LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_char,
    output logic        o_run_last,
    output logic        o_file_done
);

    logic [1:0]    r_format;
    logic [16:0]   r_image_length;
    logic [15:0]   r_base_address;
    logic          wr;
    logic          restart;
    logic [16:0]   length_next;
    logic [15:0]   base_next;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;
    hre_pkg::t_job job_in;
    hre_pkg::t_job job_out;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite && pready;
    assign restart = wr && ((paddr[3:2] == hre_pkg::REG_FORMAT) ||
                            (paddr[3:2] == hre_pkg::REG_LENGTH) ||
                            (paddr[3:2] == hre_pkg::REG_BASE));

    // restart loads the value being written in the same cycle
    assign length_next = (wr && (paddr[3:2] == hre_pkg::REG_LENGTH)) ? pwdata[16:0]
                                                                      : r_image_length;
    assign base_next   = (wr && (paddr[3:2] == hre_pkg::REG_BASE)) ? pwdata[15:0]
                                                                    : r_base_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format       <= hre_pkg::RST_FORMAT;
            r_image_length <= hre_pkg::RST_IMAGE_LENGTH;
            r_base_address <= hre_pkg::RST_BASE_ADDRESS;
        end else if (wr) begin
            case (paddr[3:2])
                hre_pkg::REG_FORMAT: r_format       <= pwdata[1:0];
                hre_pkg::REG_LENGTH: r_image_length <= pwdata[16:0];
                hre_pkg::REG_BASE:   r_base_address <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            hre_pkg::REG_FORMAT: prdata = {30'd0, r_format};
            hre_pkg::REG_LENGTH: prdata = {15'd0, r_image_length};
            hre_pkg::REG_BASE:   prdata = {16'd0, r_base_address};
            default:             prdata = 32'd0;
        endcase
    end

    hre_front #(
        .TAPE_LINE_BYTES (TAPE_LINE_BYTES),
        .IHEX_LINE_BYTES (IHEX_LINE_BYTES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (restart),
        .i_format       (r_format),
        .i_image_length (length_next),
        .i_base_address (base_next),
        .i_valid        (i_in_valid),
        .i_data_byte    (i_data_byte),
        .o_stall        (o_in_stall),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_job          (job_in)
    );

    hre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (job_out)
    );

    hre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last),
        .o_file_done (o_file_done)
    );

endmodule

>>> tb/sv/hre_stream_checker.sv
// ----------------------------------------------------------------------------
// hre_stream_checker
// watches the config port and both channels of the hex record encoder, works
// out the characters each accepted image byte must give and compares every
// accepted output character with the oldest one still owed
// ----------------------------------------------------------------------------
module hre_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  o_out_char,
    input  logic        o_run_last,
    input  logic        o_file_done,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  ASCII_A  = 8'h41;
    localparam logic [87:0] IHEX_EOF = ":00000001FF";

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       file_done;
    } t_out_char;

    t_out_char   expected_chars[$];
    t_out_char   want;
    logic [31:0] reg_now;

    logic [1:0]  out_format;
    logic [16:0] img_len;
    logic [15:0] load_base;
    logic [16:0] bytes_left;
    logic [7:0]  line_pos;
    logic [7:0]  line_len;
    logic [15:0] line_addr;
    logic [15:0] line_sum;
    logic [15:0] lines_done;

    function automatic void restart_image();
        bytes_left = img_len;
        line_addr  = load_base;
        line_pos   = '0;
        line_len   = '0;
        line_sum   = '0;
        lines_done = '0;
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        expected_chars.push_back('{ch: c, run_last: 1'b0, file_done: 1'b0});
    endfunction

    function automatic void emit_hex(input logic [15:0] v, input int digits);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = 4'(v >> (4 * i));
            emit_char(nib < 4'd10 ? hre_pkg::CH_ZERO + 8'(nib)
                                  : ASCII_A + 8'(nib) - 8'd10);
        end
    endfunction

    function automatic void encode_byte(input logic [7:0] b);
        logic        tape;
        logic        last;
        int unsigned per_line;
        int unsigned remaining;
        logic [15:0] neg_sum;
        logic [15:0] count_sum;
        if (bytes_left == '0 || out_format == hre_pkg::FMT_NONE) return;
        tape       = (out_format == hre_pkg::FMT_TAPE);
        bytes_left = bytes_left - 17'd1;
        last       = (bytes_left == '0);
        if (out_format == hre_pkg::FMT_RAW) begin
            emit_char(b);
        end else begin
            if (line_pos == '0) begin
                per_line  = tape ? hre_pkg::TAPE_LINE_BYTES_DEF
                                 : hre_pkg::IHEX_LINE_BYTES_DEF;
                remaining = bytes_left + 1;
                line_len  = 8'(remaining > per_line ? per_line : remaining);
                line_sum  = 16'(line_len) + 16'(line_addr[15:8]) + 16'(line_addr[7:0]);
                emit_char(tape ? hre_pkg::CH_SEMI : hre_pkg::CH_COLON);
                emit_hex(16'(line_len), 2);
                emit_hex(line_addr, 4);
                if (!tape) emit_hex(16'h0000, 2);
            end
            emit_hex(16'(b), 2);
            line_sum = line_sum + 16'(b);
            line_pos = line_pos + 8'd1;
            if (line_pos >= line_len || last) begin
                if (tape) begin
                    emit_hex(line_sum, 4);
                end else begin
                    neg_sum = ~line_sum + 16'd1;
                    emit_hex({8'h00, neg_sum[7:0]}, 2);
                end
                emit_char(hre_pkg::CH_NL);
                line_addr  = line_addr + 16'(line_pos);
                lines_done = lines_done + 16'd1;
                line_pos   = '0;
            end
            if (last) begin
                if (tape) begin
                    // trailer: record count and its byte sum
                    emit_char(hre_pkg::CH_SEMI);
                    emit_char(hre_pkg::CH_ZERO);
                    emit_char(hre_pkg::CH_ZERO);
                    count_sum = 16'(lines_done[15:8]) + 16'(lines_done[7:0]);
                    emit_hex(lines_done, 4);
                    emit_hex(count_sum, 4);
                end else begin
                    for (int k = 10; k >= 0; k--) emit_char(IHEX_EOF[8*k +: 8]);
                end
                emit_char(hre_pkg::CH_NL);
            end
        end
        expected_chars[expected_chars.size() - 1].run_last  = 1'b1;
        expected_chars[expected_chars.size() - 1].file_done = last;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_format = hre_pkg::RST_FORMAT;
            img_len    = hre_pkg::RST_IMAGE_LENGTH;
            load_base  = hre_pkg::RST_BASE_ADDRESS;
            restart_image();
            expected_chars.delete();
            o_fail_count = 0;
            o_chars_seen = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        hre_pkg::REG_FORMAT: begin
                            out_format = pwdata[1:0];
                            restart_image();
                        end
                        hre_pkg::REG_LENGTH: begin
                            img_len = pwdata[16:0];
                            restart_image();
                        end
                        hre_pkg::REG_BASE: begin
                            load_base = pwdata[15:0];
                            restart_image();
                        end
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        hre_pkg::REG_FORMAT: reg_now = {30'd0, out_format};
                        hre_pkg::REG_LENGTH: reg_now = {15'd0, img_len};
                        hre_pkg::REG_BASE:   reg_now = {16'd0, load_base};
                        default:             reg_now = 32'd0;
                    endcase
                    if (prdata !== reg_now) begin
                        $error("prdata at %h: expected %h, got %h", paddr, reg_now, prdata);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) encode_byte(i_data_byte);
            if (o_out_valid && !i_out_stall) begin
                o_chars_seen++;
                if (expected_chars.size() == 0) begin
                    $error("out_char: nothing expected, got %h", o_out_char);
                    o_fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (o_out_char !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, o_out_char);
                        o_fail_count++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %b, got %b", want.run_last, o_run_last);
                        o_fail_count++;
                    end
                    if (o_file_done !== want.file_done) begin
                        $error("file_done: expected %b, got %b", want.file_done, o_file_done);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_chars.size();
    end

endmodule

>>> tb/sv/tb_hex_record_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_hex_record_encoder_core
// drives image bytes and register settings into the hex record encoder with
// random gaps and output back-pressure; the stream checker beside the block
// predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_hex_record_encoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 50;
    localparam int EDGE_LENS [6] = '{24, 25, 32, 33, 48, 64};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_char;
    logic        o_run_last;
    logic        o_file_done;

    int fail_count;
    int pending;
    int chars_seen;
    int in_idle_pct   = 25;
    int out_stall_pct = 50;
    int hold_reqs     = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int bytes_taken   = 0;
    int quiet_cycles  = 0;

    always #5 i_clk = ~i_clk;

    hex_record_encoder_core dut (.*);

    hre_stream_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_chars_seen (chars_seen)
    );

    // output side: random stall, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (holds_served != hold_reqs) begin
            i_out_stall  <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("no handshake for %0d cycles, %0d characters outstanding",
                         STALL_LIMIT, pending);
                $display("[hex_record_encoder_core] ERROR");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // valid is left high after an item so that back-to-back items need no gap
    task automatic put_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid  <= 1'b0;
            i_data_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        bytes_taken++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_image(input logic [1:0] fmt, input logic [16:0] len,
                              input logic [15:0] base);
        settle();
        apb_access(1'b1, hre_pkg::REG_FORMAT, {30'd0, fmt});
        apb_access(1'b1, hre_pkg::REG_LENGTH, {15'd0, len});
        apb_access(1'b1, hre_pkg::REG_BASE, {16'd0, base});
    endtask

    task automatic random_phase(input int target);
        int         done_items;
        int         len;
        int         n;
        int         r;
        logic [1:0] fmt;
        logic [15:0] base;
        done_items = 0;
        while (done_items < target) begin
            r   = $urandom_range(0, 99);
            fmt = (r < 15) ? hre_pkg::FMT_RAW  :
                  (r < 55) ? hre_pkg::FMT_TAPE :
                  (r < 95) ? hre_pkg::FMT_IHEX : hre_pkg::FMT_NONE;
            r   = $urandom_range(0, 9);
            len = (r < 6) ? $urandom_range(1, 30) :
                  (r < 8) ? EDGE_LENS[$urandom_range(0, 5)] : $urandom_range(31, 70);
            base = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                               : 16'($urandom_range(0, 65535));
            load_image(fmt, 17'(len), base);
            n = len;
            r = $urandom_range(0, 9);
            // broken-off images and stray bytes past the end
            if (r == 0) n = $urandom_range(1, len);
            else if (r == 1) n = len + $urandom_range(1, 3);
            repeat (n) put_byte(8'($urandom_range(0, 255)));
            if (fmt != hre_pkg::FMT_NONE) done_items += (n < len) ? n : len;
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: intel hex, one byte at address zero
        put_byte(8'h00);
        settle();
        apb_access(1'b0, hre_pkg::REG_FORMAT, '0);
        apb_access(1'b0, hre_pkg::REG_LENGTH, '0);
        apb_access(1'b0, hre_pkg::REG_BASE, '0);

        load_image(hre_pkg::FMT_TAPE, 17'd3, 16'hFFFF);
        apb_access(1'b0, hre_pkg::REG_FORMAT, '0);
        apb_access(1'b0, hre_pkg::REG_LENGTH, '0);
        apb_access(1'b0, hre_pkg::REG_BASE, '0);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h01);

        load_image(hre_pkg::FMT_RAW, 17'd4, 16'h0000);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h5A);
        put_byte(8'hA5);

        // undefined format and empty image: bytes are dropped
        load_image(hre_pkg::FMT_NONE, 17'd5, 16'h1234);
        put_byte(8'h11);
        put_byte(8'hEE);
        load_image(hre_pkg::FMT_IHEX, 17'd0, 16'h1234);
        put_byte(8'h22);
        put_byte(8'hDD);

        // bytes after the end of the image
        load_image(hre_pkg::FMT_IHEX, 17'd2, 16'hABCD);
        put_byte(8'hC3);
        put_byte(8'h3C);
        put_byte(8'h7E);
        put_byte(8'hE7);

        // register write in the middle of an image restarts it
        load_image(hre_pkg::FMT_TAPE, 17'd5, 16'h0100);
        put_byte(8'h96);
        put_byte(8'h69);
        settle();
        apb_access(1'b1, hre_pkg::REG_BASE, 32'h0000_0200);
        repeat (5) put_byte(8'($urandom_range(0, 255)));

        random_phase(PHASE_ITEMS);

        in_idle_pct    = 50;
        out_stall_pct <= 25;
        random_phase(PHASE_ITEMS);

        in_idle_pct    = 0;
        out_stall_pct <= 0;
        random_phase(PHASE_ITEMS);

        // longest image lengths, address wrap, and a long output hold-off
        load_image(hre_pkg::FMT_TAPE, 17'h1FFFF, 16'hFFE0);
        repeat (10) put_byte(8'($urandom_range(0, 255)));
        hold_reqs <= hold_reqs + 1;
        repeat (40) put_byte(8'($urandom_range(0, 255)));
        load_image(hre_pkg::FMT_IHEX, 17'h10000, 16'hFFF0);
        repeat (40) put_byte(8'($urandom_range(0, 255)));
        settle();

        $display("covered %0d image bytes in raw, paper-tape and intel hex images,", bytes_taken);
        $display("with restarts, dropped bytes and address wrap; %0d characters compared",
                 chars_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[hex_record_encoder_core] OK");
        end else begin
            $display("[hex_record_encoder_core] ERROR");
        end
        $finish;
    end

endmodule
